/* rtl/cpe_pkg.sv */
// Shared types, codes and helpers of the convex polygon engine.
// Used by convex_polygon_engine, the checker and the testbench; depends on nothing.
package cpe_pkg;

  // Default configuration of the top level.
  localparam int MaxVertsDef  = 16;
  localparam int CoordBitsDef = 12;

  // Fill span bounds are 14-bit signed and saturate at these limits.
  localparam int SpanW      = 14;
  localparam int SpanMaxMag = 8191;
  localparam int SpanMinMag = 8192;
  localparam logic signed [SpanW-1:0] SpanMax = 14'sh1FFF;
  localparam logic signed [SpanW-1:0] SpanMin = 14'sh2000;

  // Action codes carried by an input beat.
  typedef enum logic [1:0] {
    ActAdd   = 2'd0,
    ActTest  = 2'd1,
    ActSpan  = 2'd2,
    ActClear = 2'd3
  } action_e;

  // Point test answers.
  localparam logic [1:0] PosInside   = 2'd0;
  localparam logic [1:0] PosBoundary = 2'd1;
  localparam logic [1:0] PosOutside  = 2'd2;

  // Clamp an unsigned coordinate (zero extended to 16 bits) into span range.
  function automatic logic signed [SpanW-1:0] sat_coord(input logic [15:0] v);
    logic signed [SpanW-1:0] r;
    r = (v > 16'(SpanMaxMag)) ? SpanMax : $signed(v[SpanW-1:0]);
    return r;
  endfunction

endpackage

/* rtl/convex_polygon_engine.sv */
// Top level of the convex polygon engine: vertex store, sequencer, shared multiplier.
// Depends on cpe_pkg and cpe_divider.
//
// Usage: one input beat (action, x_coord, y_coord) gives exactly one result beat.
// Both channels use valid/ready; in_ready_o is high only while the engine is idle,
// and the result is held in output registers until out_ready_i takes it. A stalled
// receiver simply holds the engine idle-with-result; nothing is lost.
// The convex_only register is written with cfg_we_i/cfg_wdata_i at any edge.
// Clear, an add to a full store, an add leaving fewer than three vertices and a test
// or span of an empty polygon go straight to the result. Add vertex and test point
// walk the n stored vertices (add vertex counts the new one); span walks them too
// and waits on each non-horizontal edge for the one-bit-per-cycle divider.
// Each edge passes through one vertex memory read and one shared multiplier used
// twice, so items are handled one at a time.
// After reset the polygon is empty, convex, orientation 0, convex_only 0; no
// memory clearing pass is needed since only written entries are ever read.
module convex_polygon_engine #(
  parameter int MAX_VERTS  = cpe_pkg::MaxVertsDef,
  parameter int COORD_BITS = cpe_pkg::CoordBitsDef,
  localparam int CW = $clog2(MAX_VERTS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [COORD_BITS-1:0]             x_coord_i,
  input  logic [COORD_BITS-1:0]             y_coord_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic                              is_convex_o,
  output logic                              orientation_o,
  output logic [1:0]                        position_o,
  output logic                              span_valid_o,
  output logic signed [cpe_pkg::SpanW-1:0]  span_left_o,
  output logic signed [cpe_pkg::SpanW-1:0]  span_right_o,
  output logic [CW-1:0]                     vertex_total_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int SW = 2 * C + 3;
  localparam int AW = $clog2(MAX_VERTS);
  localparam int KW = $clog2(MAX_VERTS + 3);
  localparam int SP = cpe_pkg::SpanW;
  localparam logic [SW-1:0] PosLim = SW'(cpe_pkg::SpanMaxMag);
  localparam logic [SW-1:0] NegLim = SW'(cpe_pkg::SpanMinMag);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_READ = 8'b00000010,
    S_LOAD = 8'b00000100,
    S_MUL1 = 8'b00001000,
    S_MUL2 = 8'b00010000,
    S_EVAL = 8'b00100000,
    S_DIV  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_e;

  // The result hold state shares the idle code space through out_busy_q.
  state_e state_q, state_d;
  logic   out_busy_q, out_busy_d;

  logic                  cfg_q;
  logic [CW-1:0]         count_q;
  logic                  cv_q, ori_q;

  cpe_pkg::action_e      act_q;
  logic [C-1:0]          px_q, py_q;
  logic [CW-1:0]         n_q;
  logic [KW-1:0]         k_q;
  logic                  full_q;
  logic                  above_q, below_q, on_q, out_q;
  logic                  hit_q, left_q, neg_q;
  logic signed [SP-1:0]  hl_q, hr_q, lq_q, rq_q;
  logic [C-1:0]          xmin_q, xmax_q, ymin_q, ymax_q;
  logic [C-1:0]          w0x_q, w0y_q, w1x_q, w1y_q, w2x_q, w2y_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [SW-1:0]  acc_q;

  logic                  res_acc_q, res_valid_q;
  logic [1:0]            res_pos_q;
  logic signed [SP-1:0]  res_left_q, res_right_q;

  logic [2*C-1:0]        mem [MAX_VERTS];
  logic [2*C-1:0]        rd_q;
  logic [AW-1:0]         rd_addr;
  logic [KW-1:0]         k_wrap;
  logic                  in_fire, mem_we;

  function automatic logic signed [DW-1:0] diff(input logic [C-1:0] a, input logic [C-1:0] b);
    logic signed [DW-1:0] r;
    r = $signed({1'b0, a}) - $signed({1'b0, b});
    return r;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE) && !out_busy_q;
  assign out_valid_o = out_busy_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign mem_we      = in_fire && (cpe_pkg::action_e'(action_i) == cpe_pkg::ActAdd) &&
                       (count_q < CW'(MAX_VERTS));

  // Vertex memory: write on an accepted add, registered read of the streamed index.
  assign k_wrap  = (k_q >= KW'(n_q)) ? k_q - KW'(n_q) : k_q;
  assign rd_addr = k_wrap[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= {x_coord_i, y_coord_i};
    end
    rd_q <= mem[rd_addr];
  end

  // Edge and probe point selection; classify uses three consecutive vertices.
  logic                  cls, spn, last;
  logic [C-1:0]          ex0, ey0, ex1, ey1, qx, qy;
  logic signed [DW-1:0]  u1, v1, u2, v2, mul_a, mul_b;
  logic signed [PW-1:0]  prod_w;
  logic [DW-1:0]         a_abs;
  logic [SW-1:0]         acc_abs;
  logic                  div_done;
  logic [SW-1:0]         div_quot;
  logic signed [SP-1:0]  q_sat, lbase, rbase;
  logic                  div_start, closing;

  always_comb begin
    cls  = (act_q == cpe_pkg::ActAdd);
    spn  = (act_q == cpe_pkg::ActSpan);
    ex0  = cls ? w0x_q : w1x_q;
    ey0  = cls ? w0y_q : w1y_q;
    ex1  = cls ? w1x_q : w2x_q;
    ey1  = cls ? w1y_q : w2y_q;
    qx   = cls ? w2x_q : px_q;
    qy   = cls ? w2y_q : py_q;
    if (spn) begin
      u1 = diff(ey0, ey1);
      v1 = $signed({1'b0, ex0});
      u2 = diff(ex1, ex0);
      v2 = diff(ey0, py_q);
    end else begin
      u1 = diff(ex1, ex0);
      v1 = diff(qy, ey0);
      u2 = diff(ey1, ey0);
      v2 = diff(ex0, qx);
    end
    mul_a   = (state_q == S_MUL1) ? u1 : u2;
    mul_b   = (state_q == S_MUL1) ? v1 : v2;
    a_abs   = u1[DW-1] ? DW'(~u1 + 1'b1) : DW'(u1);
    acc_abs = acc_q[SW-1] ? SW'(~acc_q + 1'b1) : SW'(acc_q);
    last    = cls ? (k_q == KW'(n_q) + KW'(2)) : (k_q == KW'(n_q) + KW'(1));
    closing = (k_q == KW'(n_q) + KW'(1));
    div_start = (state_q == S_EVAL) && spn && (u1 != '0);
  end

  // Shared multiplier.
  assign prod_w = mul_a * mul_b;

  cpe_divider #(
    .NUM_W (SW),
    .DEN_W (C)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_abs),
    .den_i   (a_abs[C-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Saturate the signed quotient and the bounding box into span range.
  always_comb begin
    if (neg_q) begin
      q_sat = (div_quot > NegLim) ? cpe_pkg::SpanMin : SP'(~div_quot[SP-1:0] + 1'b1);
    end else begin
      q_sat = (div_quot > PosLim) ? cpe_pkg::SpanMax : $signed(div_quot[SP-1:0]);
    end
    lbase = cpe_pkg::sat_coord(16'(xmin_q));
    rbase = cpe_pkg::sat_coord(16'(xmax_q));
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    out_busy_d = out_busy_q;
    case (state_q)
      S_IDLE: begin
        if (out_busy_q) begin
          if (out_ready_i) out_busy_d = 1'b0;
        end else if (in_valid_i) begin
          case (cpe_pkg::action_e'(action_i))
            cpe_pkg::ActAdd: begin
              state_d = ((count_q == CW'(MAX_VERTS)) || (count_q < CW'(2))) ? S_FIN : S_READ;
            end
            cpe_pkg::ActTest, cpe_pkg::ActSpan: begin
              state_d = (count_q == '0) ? S_FIN : S_READ;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_READ: state_d = S_LOAD;
      S_LOAD: state_d = (k_q >= (cls ? KW'(2) : KW'(1))) ? S_MUL1 : S_READ;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_EVAL;
      S_EVAL: begin
        if (div_start) state_d = S_DIV;
        else           state_d = last ? S_FIN : S_READ;
      end
      S_DIV: begin
        if (div_done) state_d = last ? S_FIN : S_READ;
      end
      S_FIN: begin
        state_d    = S_IDLE;
        out_busy_d = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_busy_q <= 1'b0;
      cfg_q      <= 1'b0;
      count_q    <= '0;
      cv_q       <= 1'b1;
      ori_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_busy_q <= out_busy_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (state_q == S_FIN) begin
        case (act_q)
          cpe_pkg::ActAdd: begin
            if (!full_q && !(cfg_q && below_q && above_q)) begin
              count_q <= n_q;
              cv_q    <= !below_q || !above_q;
              ori_q   <= below_q && !above_q;
            end
          end
          cpe_pkg::ActClear: begin
            count_q <= '0;
            cv_q    <= 1'b1;
            ori_q   <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_q   <= cpe_pkg::action_e'(action_i);
          px_q    <= x_coord_i;
          py_q    <= y_coord_i;
          full_q  <= (count_q == CW'(MAX_VERTS));
          n_q     <= (cpe_pkg::action_e'(action_i) == cpe_pkg::ActAdd) ?
                     CW'(count_q + 1'b1) : count_q;
          k_q     <= '0;
          above_q <= 1'b0;
          below_q <= 1'b0;
          on_q    <= 1'b0;
          out_q   <= 1'b0;
          hit_q   <= 1'b0;
          lq_q    <= cpe_pkg::SpanMin;
          rq_q    <= cpe_pkg::SpanMax;
        end
      end
      S_LOAD: begin
        w0x_q <= w1x_q;
        w0y_q <= w1y_q;
        w1x_q <= w2x_q;
        w1y_q <= w2y_q;
        w2x_q <= rd_q[2*C-1:C];
        w2y_q <= rd_q[C-1:0];
        k_q   <= k_q + 1'b1;
        // Bounding box over the stored vertices for a span.
        if (spn && (k_q < KW'(n_q))) begin
          if (k_q == '0 || rd_q[2*C-1:C] < xmin_q) xmin_q <= rd_q[2*C-1:C];
          if (k_q == '0 || rd_q[2*C-1:C] > xmax_q) xmax_q <= rd_q[2*C-1:C];
          if (k_q == '0 || rd_q[C-1:0] < ymin_q)   ymin_q <= rd_q[C-1:0];
          if (k_q == '0 || rd_q[C-1:0] > ymax_q)   ymax_q <= rd_q[C-1:0];
        end
      end
      S_MUL1: prod_q <= prod_w;
      S_MUL2: acc_q  <= SW'(prod_q) + SW'(prod_w);
      S_EVAL: begin
        case (act_q)
          cpe_pkg::ActAdd: begin
            if (!acc_q[SW-1] && acc_q != '0) above_q <= 1'b1;
            if (acc_q[SW-1])                 below_q <= 1'b1;
          end
          cpe_pkg::ActTest: begin
            if (acc_q == '0) on_q <= 1'b1;
            else if (ori_q ? !acc_q[SW-1] : acc_q[SW-1]) out_q <= 1'b1;
          end
          cpe_pkg::ActSpan: begin
            // A horizontal edge on the row wins; the closing edge takes priority over the others.
            if (u1 == '0) begin
              if (ey0 == py_q && (!hit_q || closing)) begin
                hit_q <= 1'b1;
                hl_q  <= cpe_pkg::sat_coord(16'((ex0 < ex1) ? ex0 : ex1));
                hr_q  <= cpe_pkg::sat_coord(16'((ex0 < ex1) ? ex1 : ex0));
              end
            end else begin
              left_q <= !u1[DW-1];
              neg_q  <= acc_q[SW-1] ^ u1[DW-1];
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          if (left_q) begin
            if (q_sat > lq_q) lq_q <= q_sat;
          end else begin
            if (q_sat < rq_q) rq_q <= q_sat;
          end
        end
      end
      default: ;
    endcase
  end

  // Result registers, loaded once per item.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      res_acc_q   <= 1'b0;
      res_pos_q   <= cpe_pkg::PosInside;
      res_valid_q <= 1'b0;
      res_left_q  <= '0;
      res_right_q <= '0;
      case (act_q)
        cpe_pkg::ActAdd: begin
          res_acc_q <= !full_q && !(cfg_q && below_q && above_q);
        end
        cpe_pkg::ActTest: begin
          if (n_q == '0 || out_q) res_pos_q <= cpe_pkg::PosOutside;
          else if (on_q)          res_pos_q <= cpe_pkg::PosBoundary;
          else                    res_pos_q <= cpe_pkg::PosInside;
        end
        cpe_pkg::ActSpan: begin
          if (n_q != '0 && ymin_q <= py_q && py_q <= ymax_q) begin
            res_valid_q <= 1'b1;
            res_left_q  <= hit_q ? hl_q : ((lq_q > lbase) ? lq_q : lbase);
            res_right_q <= hit_q ? hr_q : ((rq_q < rbase) ? rq_q : rbase);
          end
        end
        default: ;
      endcase
    end
  end

  assign accepted_o     = res_acc_q;
  assign is_convex_o    = cv_q;
  assign orientation_o  = ori_q;
  assign position_o     = res_pos_q;
  assign span_valid_o   = res_valid_q;
  assign span_left_o    = res_left_q;
  assign span_right_o   = res_right_q;
  assign vertex_total_o = count_q;

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input ready while a result is pending");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTS)) else $error("vertex count beyond the store");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished outside the divide step");

  a_accept_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> vertex_total_o != '0)
    else $error("vertex stored but count is zero");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> out_valid_o) else $error("result not raised after an item");
`endif

endmodule

/* rtl/cpe_divider.sv */
// Iterative restoring divider for unsigned magnitudes, one quotient bit a cycle.
// Used by convex_polygon_engine for the scanline crossing of each edge; no package needed.
module cpe_divider #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* dv/convex_polygon_checker.sv */
// Checker for the convex polygon engine: watches both channels, predicts each
// result from its own polygon state and compares field by field. Uses cpe_pkg.
module convex_polygon_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        action_i,
  input  logic [11:0]                       x_coord_i,
  input  logic [11:0]                       y_coord_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              accepted_i,
  input  logic                              is_convex_i,
  input  logic                              orientation_i,
  input  logic [1:0]                        position_i,
  input  logic                              span_valid_i,
  input  logic signed [cpe_pkg::SpanW-1:0]  span_left_i,
  input  logic signed [cpe_pkg::SpanW-1:0]  span_right_i,
  input  logic [4:0]                        vertex_total_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic                             accepted;
    logic                             is_convex;
    logic                             orientation;
    logic [1:0]                       position;
    logic                             span_valid;
    logic signed [cpe_pkg::SpanW-1:0] span_left;
    logic signed [cpe_pkg::SpanW-1:0] span_right;
    logic [4:0]                       vertex_total;
  } poly_result_t;

  localparam int MaxVerts = 16;

  longint       vx [MaxVerts];
  longint       vy [MaxVerts];
  int           vcount;
  logic         convex_st;
  logic         orient_st;
  logic         convex_only;
  poly_result_t expected_q[$];
  int           fails;

  assign fail_count_o = fails;

  // Line coefficients of edge e in a polygon of n vertices.
  function automatic void edge_line(input int e, input int n,
                                    output longint a, output longint b, output longint c);
    int f;
    f = (e + 1) % n;
    a = vy[e] - vy[f];
    b = vx[f] - vx[e];
    c = vx[e] * vy[f] - vy[e] * vx[f];
  endfunction

  // Convexity and orientation from each vertex against the edge two before it.
  function automatic void shape_of(input int n, output logic cv, output logic ori);
    int above, below, e;
    longint a, b, c, r;
    above = 0;
    below = 0;
    for (int i = 0; i < n; i++) begin
      e = (i + 2 * n - 2) % n;
      edge_line(e, n, a, b, c);
      r = a * vx[i] + b * vy[i] + c;
      if (r > 0) above++;
      else if (r < 0) below++;
    end
    cv = 1'b0;
    ori = 1'b0;
    if (below == 0) cv = 1'b1;
    else if (above == 0) begin
      cv = 1'b1;
      ori = 1'b1;
    end
  endfunction

  function automatic logic [1:0] locate_point(input longint x, input longint y);
    longint a, b, c, r;
    logic on, outside;
    on = 1'b0;
    outside = 1'b0;
    if (vcount == 0) return cpe_pkg::PosOutside;
    for (int e = 0; e < vcount; e++) begin
      edge_line(e, vcount, a, b, c);
      r = a * x + b * y + c;
      if (r == 0) on = 1'b1;
      else if (orient_st ? (r > 0) : (r < 0)) outside = 1'b1;
    end
    if (outside) return cpe_pkg::PosOutside;
    return on ? cpe_pkg::PosBoundary : cpe_pkg::PosInside;
  endfunction

  function automatic logic signed [cpe_pkg::SpanW-1:0] clamp_span(input longint v);
    if (v < -8192) return cpe_pkg::SpanMin;
    if (v > 8191) return cpe_pkg::SpanMax;
    return cpe_pkg::SpanW'(v);
  endfunction

  // Fill span of row y; returns 0 when the row misses the polygon.
  function automatic logic row_span(input longint y, output longint lo, output longint hi);
    longint xmin, xmax, ymin, ymax, a, b, c, q;
    int n, e, f;
    n = vcount;
    if (n == 0) return 1'b0;
    xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0];
    for (int i = 1; i < n; i++) begin
      if (vx[i] < xmin) xmin = vx[i];
      if (vx[i] > xmax) xmax = vx[i];
      if (vy[i] < ymin) ymin = vy[i];
      if (vy[i] > ymax) ymax = vy[i];
    end
    if (y < ymin || y > ymax) return 1'b0;
    lo = xmin;
    hi = xmax;
    for (int k = 0; k < n; k++) begin
      e = (k + n - 1) % n;
      f = (e + 1) % n;
      edge_line(e, n, a, b, c);
      if (a == 0) begin
        if (vy[e] == y) begin
          if (vx[e] < vx[f]) begin lo = vx[e]; hi = vx[f]; end
          else begin lo = vx[f]; hi = vx[e]; end
          break;
        end
      end else begin
        q = (-b * y - c) / a;
        if (a > 0) begin if (q > lo) lo = q; end
        else begin if (q < hi) hi = q; end
      end
    end
    return 1'b1;
  endfunction

  // Apply one input beat to the predicted state and return its result.
  function automatic poly_result_t apply_beat(input logic [1:0] act,
                                              input logic [11:0] x, input logic [11:0] y);
    poly_result_t res;
    logic cv, ori;
    longint lo, hi;
    res = '0;
    case (cpe_pkg::action_e'(act))
      cpe_pkg::ActAdd: begin
        if (vcount < MaxVerts) begin
          vx[vcount] = x;
          vy[vcount] = y;
          shape_of(vcount + 1, cv, ori);
          if (!(convex_only && !cv)) begin
            vcount++;
            convex_st = cv;
            orient_st = ori;
            res.accepted = 1'b1;
          end
        end
      end
      cpe_pkg::ActTest: res.position = locate_point(x, y);
      cpe_pkg::ActSpan: begin
        if (row_span(y, lo, hi)) begin
          res.span_valid = 1'b1;
          res.span_left  = clamp_span(lo);
          res.span_right = clamp_span(hi);
        end
      end
      default: begin
        vcount = 0;
        convex_st = 1'b1;
        orient_st = 1'b0;
      end
    endcase
    res.is_convex    = convex_st;
    res.orientation  = orient_st;
    res.vertex_total = 5'(vcount);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    poly_result_t want;
    if (!rst_ni) begin
      vcount = 0;
      convex_st = 1'b1;
      orient_st = 1'b0;
      convex_only = 1'b0;
      fails = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) convex_only = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(), apply_beat(action_i, x_coord_i, y_coord_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) report_mismatch("unexpected result beat", 1, 0);
        else begin
          want = expected_q.pop_front();
          if (accepted_i !== want.accepted)
            report_mismatch("accepted", accepted_i, want.accepted);
          if (is_convex_i !== want.is_convex)
            report_mismatch("is_convex", is_convex_i, want.is_convex);
          if (orientation_i !== want.orientation)
            report_mismatch("orientation", orientation_i, want.orientation);
          if (position_i !== want.position)
            report_mismatch("position", position_i, want.position);
          if (span_valid_i !== want.span_valid)
            report_mismatch("span_valid", span_valid_i, want.span_valid);
          if (span_left_i !== want.span_left)
            report_mismatch("span_left", span_left_i, want.span_left);
          if (span_right_i !== want.span_right)
            report_mismatch("span_right", span_right_i, want.span_right);
          if (vertex_total_i !== want.vertex_total)
            report_mismatch("vertex_total", vertex_total_i, want.vertex_total);
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

/* dv/convex_polygon_engine_tb.sv */
// Testbench top of the convex polygon engine: clock, reset, stimulus, verdict.
// Depends on cpe_pkg, convex_polygon_engine and convex_polygon_checker.
module convex_polygon_engine_tb;

  localparam longint CycleLimit = 3_000_000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic                              cfg_wdata_i = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        action_i = cpe_pkg::ActClear;
  logic [11:0]                       x_coord_i = '0;
  logic [11:0]                       y_coord_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              accepted_o, is_convex_o, orientation_o, span_valid_o;
  logic [1:0]                        position_o;
  logic signed [cpe_pkg::SpanW-1:0]  span_left_o, span_right_o;
  logic [4:0]                        vertex_total_o;
  int                                fail_count, pending;
  longint                            cycle_count = 0;
  int                                sent_count = 0;
  bit                                hold_off = 1'b0;
  bit                                stim_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  convex_polygon_engine u_top (.*);

  convex_polygon_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .action_i, .x_coord_i, .y_coord_i,
    .out_valid_i(out_valid_o), .out_ready_i, .accepted_i(accepted_o),
    .is_convex_i(is_convex_o), .orientation_i(orientation_o), .position_i(position_o),
    .span_valid_i(span_valid_o), .span_left_i(span_left_o), .span_right_i(span_right_o),
    .vertex_total_i(vertex_total_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall per beat, plus one long hold-off on request.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      if (hold_off && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one beat after a random gap (none with no_gap); valid stays up until accepted.
  task automatic send_beat(input logic [1:0] act, input logic [11:0] x, input logic [11:0] y,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random coordinate: mostly small, some extremes.
  function automatic logic [11:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 12'h000;
      1: return 12'hFFF;
      2, 3: return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(100, 300));
    endcase
  endfunction

  // Convex polygon on a circle with some random stray vertices, then random queries.
  task automatic polygon_session(input bit quick);
    int nv, cx, cy, rad;
    real ang;
    nv = $urandom_range(1, 18);
    cx = $urandom_range(600, 3500);
    cy = $urandom_range(600, 3500);
    rad = $urandom_range(2, 500);
    send_beat(cpe_pkg::ActClear, rand_coord(), rand_coord(), quick);
    for (int i = 0; i < nv; i++) begin
      ang = 6.2831853 * i / nv;
      if ($urandom_range(0, 7) == 0)
        send_beat(cpe_pkg::ActAdd, rand_coord(), rand_coord(), quick);
      else
        send_beat(cpe_pkg::ActAdd, 12'(cx + $rtoi(rad * $cos(ang))),
                  12'(cy + $rtoi(rad * $sin(ang))), quick);
    end
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 1))
        send_beat(cpe_pkg::ActTest, 12'(cx + $urandom_range(0, 2 * rad) - rad),
                  12'(cy + $urandom_range(0, 2 * rad) - rad), quick);
      else
        send_beat(cpe_pkg::ActSpan, rand_coord(),
                  12'(cy + $urandom_range(0, 2 * rad) - rad), quick);
    end
    if ($urandom_range(0, 3) == 0)
      send_beat(cpe_pkg::action_e'($urandom_range(0, 3)), rand_coord(), rand_coord(), quick);
  endtask

  // Stimulus.
  initial begin
    int ph;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every action, empty, single vertex, horizontal edges.
    send_beat(cpe_pkg::ActTest, 12'd5, 12'd5, 1'b0);
    send_beat(cpe_pkg::ActSpan, 12'd0, 12'd5, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd100, 12'd100, 1'b0);
    send_beat(cpe_pkg::ActTest, 12'd7, 12'd9, 1'b0);
    send_beat(cpe_pkg::ActSpan, 12'd0, 12'd100, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'hFFF, 12'd100, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'hFFF, 12'hFFF, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd0, 12'hFFF, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd0, 12'd0, 1'b0);
    send_beat(cpe_pkg::ActTest, 12'd2000, 12'd2000, 1'b0);
    send_beat(cpe_pkg::ActTest, 12'd0, 12'd2000, 1'b0);
    send_beat(cpe_pkg::ActTest, 12'd0, 12'd50, 1'b0);
    send_beat(cpe_pkg::ActSpan, 12'd0, 12'd100, 1'b0);
    send_beat(cpe_pkg::ActSpan, 12'd0, 12'd3000, 1'b0);
    send_beat(cpe_pkg::ActSpan, 12'd0, 12'hFFF, 1'b0);
    send_beat(cpe_pkg::ActSpan, 12'd0, 12'd0, 1'b0);
    send_beat(cpe_pkg::ActClear, 12'hFFF, 12'hFFF, 1'b0);
    send_beat(cpe_pkg::ActTest, 12'hABC, 12'h543, 1'b0);
    write_mode(1'b1);
    send_beat(cpe_pkg::ActAdd, 12'd0, 12'd0, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd400, 12'd0, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd400, 12'd400, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd300, 12'd100, 1'b0);
    send_beat(cpe_pkg::ActAdd, 12'd0, 12'd400, 1'b0);
    send_beat(cpe_pkg::ActTest, 12'd400, 12'd200, 1'b0);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off = 1'b1;
    polygon_session(1'b1);

    // Random phases over both mode settings.
    ph = 0;
    while (sent_count < 560) begin
      write_mode(ph[0]);
      for (int s = 0; s < 5; s++) polygon_session(1'b0);
      ph++;
    end
    drain_results();
    stim_done = 1'b1;
  end

  // Verdict.
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/cpe_pkg.sv
rtl/cpe_divider.sv
rtl/convex_polygon_engine.sv
dv/convex_polygon_checker.sv
dv/convex_polygon_engine_tb.sv
